### hdl/jsu_pkg.sv
// package for the json string unescape block
// types, code constants and small decode functions; no dependencies
package jsu_pkg;

    // decoder modes, codes above hex act as wait
    typedef enum logic [2:0] {
        MODE_WAIT = 3'd0,
        MODE_BODY = 3'd1,
        MODE_ESC  = 3'd2,
        MODE_HEX  = 3'd3
    } t_mode;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NO_QUOTE     = 3'd0;
    localparam logic [2:0] ERR_UNTERMINATED = 3'd1;
    localparam logic [2:0] ERR_CONTROL      = 3'd2;
    localparam logic [2:0] ERR_TRUNC_ESC    = 3'd3;
    localparam logic [2:0] ERR_BAD_ESC      = 3'd4;
    localparam logic [2:0] ERR_TRUNC_HEX    = 3'd5;
    localparam logic [2:0] ERR_BAD_HEX      = 3'd6;
    localparam logic [2:0] ERR_SURROGATE    = 3'd7;

    localparam logic [7:0] CHR_QUOTE     = 8'h22;
    localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHR_U         = 8'h75;
    localparam logic [7:0] CHR_SPACE     = 8'h20;

    localparam int MaxResults = 3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_end;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] result_kind;
        logic [2:0] error_code;
        logic       last_of_run;
    } t_out_word;

    // results caused by one input word
    typedef struct packed {
        logic [1:0]                     count;
        t_out_word [MaxResults-1:0]     words;
    } t_res_group;

    function automatic t_out_word mk_word(input logic [7:0] b, input logic [1:0] kind,
                                          input logic [2:0] err);
        t_out_word w;
        w.out_byte    = b;
        w.result_kind = kind;
        w.error_code  = err;
        w.last_of_run = 1'b0;
        return w;
    endfunction

    // {valid, digit value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // {valid, byte} for two-character escapes
    function automatic logic [8:0] escape_byte(input logic [7:0] c);
        logic [8:0] r;
        r = 9'd0;
        case (c)
            8'h22:   r = {1'b1, 8'h22};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h2F:   r = {1'b1, 8'h2F};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0C};
            8'h6E:   r = {1'b1, 8'h0A};
            8'h72:   r = {1'b1, 8'h0D};
            8'h74:   r = {1'b1, 8'h09};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

### hdl/jsu_decode.sv
// decode state and per-word decode logic of the json string unescape block
// depends on jsu_pkg
module jsu_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  jsu_pkg::t_in_word   i_word,
    output jsu_pkg::t_res_group o_group
);
    import jsu_pkg::*;

    t_mode       r_mode, n_mode;
    logic [15:0] r_acc, n_acc;
    logic [1:0]  r_seen, n_seen;

    logic [7:0]  c;
    logic        te;
    logic [4:0]  hv;
    logic [8:0]  eb;
    logic [15:0] cp;
    t_res_group  grp;

    assign c  = i_word.text_byte;
    assign te = i_word.text_end;
    assign hv = hex_value(c);
    assign eb = escape_byte(c);
    assign cp = {r_acc[11:0], hv[3:0]};

    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        n_seen = r_seen;
        grp    = '0;
        unique case (r_mode)
            MODE_BODY: begin
                if (te) begin
                    grp.count = 2'd1;
                    grp.words[0] = mk_word(8'd0, KIND_ERROR, ERR_UNTERMINATED);
                    n_mode = MODE_WAIT;
                    n_acc  = '0;
                    n_seen = '0;
                end else if (c == CHR_QUOTE) begin
                    grp.count = 2'd1;
                    grp.words[0] = mk_word(8'd0, KIND_DONE, 3'd0);
                    n_mode = MODE_WAIT;
                end else if (c < CHR_SPACE) begin
                    grp.count = 2'd1;
                    grp.words[0] = mk_word(8'd0, KIND_ERROR, ERR_CONTROL);
                    n_mode = MODE_WAIT;
                    n_acc  = '0;
                    n_seen = '0;
                end else if (c == CHR_BACKSLASH) begin
                    n_mode = MODE_ESC;
                end else begin
                    grp.count = 2'd1;
                    grp.words[0] = mk_word(c, KIND_BYTE, 3'd0);
                end
            end
            MODE_ESC: begin
                if (te || !(c == CHR_U || eb[8])) begin
                    grp.count = 2'd1;
                    grp.words[0] = mk_word(8'd0, KIND_ERROR,
                                           te ? ERR_TRUNC_ESC : ERR_BAD_ESC);
                    n_mode = MODE_WAIT;
                    n_acc  = '0;
                    n_seen = '0;
                end else if (c == CHR_U) begin
                    n_mode = MODE_HEX;
                    n_acc  = '0;
                    n_seen = '0;
                end else begin
                    grp.count = 2'd1;
                    grp.words[0] = mk_word(eb[7:0], KIND_BYTE, 3'd0);
                    n_mode = MODE_BODY;
                end
            end
            MODE_HEX: begin
                if (te || !hv[4]) begin
                    grp.count = 2'd1;
                    grp.words[0] = mk_word(8'd0, KIND_ERROR,
                                           te ? ERR_TRUNC_HEX : ERR_BAD_HEX);
                    n_mode = MODE_WAIT;
                    n_acc  = '0;
                    n_seen = '0;
                end else if (r_seen != 2'd3) begin
                    n_acc  = cp;
                    n_seen = r_seen + 2'd1;
                end else begin
                    n_acc  = '0;
                    n_seen = '0;
                    if (cp[15:11] == 5'b11011) begin
                        // surrogate range d800..dfff
                        grp.count = 2'd1;
                        grp.words[0] = mk_word(8'd0, KIND_ERROR, ERR_SURROGATE);
                        n_mode = MODE_WAIT;
                    end else begin
                        n_mode = MODE_BODY;
                        if (cp[15:7] == '0) begin
                            grp.count = 2'd1;
                            grp.words[0] = mk_word({1'b0, cp[6:0]}, KIND_BYTE, 3'd0);
                        end else if (cp[15:11] == '0) begin
                            grp.count = 2'd2;
                            grp.words[0] = mk_word({3'b110, cp[10:6]}, KIND_BYTE, 3'd0);
                            grp.words[1] = mk_word({2'b10, cp[5:0]}, KIND_BYTE, 3'd0);
                        end else begin
                            grp.count = 2'd3;
                            grp.words[0] = mk_word({4'b1110, cp[15:12]}, KIND_BYTE, 3'd0);
                            grp.words[1] = mk_word({2'b10, cp[11:6]}, KIND_BYTE, 3'd0);
                            grp.words[2] = mk_word({2'b10, cp[5:0]}, KIND_BYTE, 3'd0);
                        end
                    end
                end
            end
            default: begin
                // waiting for the opening quote
                n_acc  = '0;
                n_seen = '0;
                if (!te && c == CHR_QUOTE) begin
                    n_mode = MODE_BODY;
                end else begin
                    grp.count = 2'd1;
                    grp.words[0] = mk_word(8'd0, KIND_ERROR, ERR_NO_QUOTE);
                    n_mode = MODE_WAIT;
                end
            end
        endcase
    end

    // flag the final result of the group
    always_comb begin
        o_group = grp;
        for (int i = 0; i < MaxResults; i++) begin
            o_group.words[i].last_of_run = (grp.count == 2'(i + 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_WAIT;
            r_acc  <= '0;
            r_seen <= '0;
        end else if (i_advance) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_seen <= n_seen;
        end
    end

endmodule

### hdl/jsu_out_buf.sv
// result register holding the results of one word, sent one per cycle while not stalled
// depends on jsu_pkg
module jsu_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  jsu_pkg::t_res_group i_group,
    output logic                o_free,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output jsu_pkg::t_out_word  o_out_word
);
    import jsu_pkg::*;

    logic [1:0]                 r_cnt;
    logic [1:0]                 r_idx;
    t_out_word [MaxResults-1:0] r_words;
    logic                       taken;
    logic                       last;

    assign o_out_valid = (r_cnt != 2'd0);
    assign taken       = o_out_valid && !i_out_stall;
    assign last        = (r_idx == r_cnt - 2'd1);
    assign o_free      = !o_out_valid || (taken && last);

    always_comb begin
        case (r_idx)
            2'd0:    o_out_word = r_words[0];
            2'd1:    o_out_word = r_words[1];
            default: o_out_word = r_words[2];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_load) begin
            r_cnt <= i_group.count;
            r_idx <= '0;
        end else if (taken) begin
            if (last) begin
                r_cnt <= '0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_words <= i_group.words;
        end
    end

endmodule

### hdl/json_string_unescape_utf8_top.sv
// json string unescape block, streaming text bytes to decoded utf-8 bytes
// top level: input register, decoder and result register; depends on jsu_pkg
//
// input channel: one text word per accept (i_in_valid high, o_in_stall low),
//   a byte of text or an end-of-text marker
// output channel: result words (o_out_valid high, i_out_stall low), each a
//   decoded byte, a string-closed mark or an error code; last_of_run marks the
//   final result caused by one input word
// path: an accepted word is held in the input register, decoded from there, and its
//   first result is loaded into the result register once that is free, visible from then on
// throughput: one word per cycle while the receiver does not stall and each word gives at
//   most one result; a \u escape that expands to two or three utf-8 bytes holds the
//   result register until all its bytes are sent, since it drains one word a cycle
// stall: while the receiver stalls the current result holds and the input stalls
//   once its register is full; every held word, even one with no result, waits
//   until the result register is empty or hands over its final word that cycle
// reset: synchronous, active low; clears both registers' valid state and returns
//   the decoder to waiting for an opening quote
module json_string_unescape_utf8_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  jsu_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output jsu_pkg::t_out_word o_out_word
);
    import jsu_pkg::*;

    // input register
    logic       r_in_valid;
    t_in_word   r_in_word;

    logic       buf_free;
    logic       advance;
    t_res_group dec_group;

    // the held word moves on when the result register can take its results
    assign advance    = r_in_valid && buf_free;
    assign o_in_stall = r_in_valid && !buf_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_word <= i_in_word;
        end
    end

    jsu_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_word    (r_in_word),
        .o_group   (dec_group)
    );

    // words with no result (opening quote, backslash, early hex digits) skip the load
    jsu_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance && (dec_group.count != 2'd0)),
        .i_group     (dec_group),
        .o_free      (buf_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

`ifndef SYNTHESIS
    // done and error results always end their run
    a_single_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.result_kind != KIND_BYTE) |-> o_out_word.last_of_run)
        else $error("done or error result not flagged last");

    // no undefined result kind leaves the block
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.result_kind != 2'd3))
        else $error("undefined result kind");

    // error results carry no byte
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.result_kind == KIND_ERROR) |->
        (o_out_word.out_byte == 8'd0))
        else $error("error result with nonzero byte");

    // input only backs up behind a pending result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty result register");
`endif

endmodule
